[design/ppm_pkg.sv]
// Shared types and constants for the particle pool manager.
`timescale 1ns / 1ps
`default_nettype none
package ppm_pkg;

	// Operation codes
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_MAX_COUNT   = 3'd0;
	localparam logic [2:0] CFG_OPACITY_MIN = 3'd1;
	localparam logic [2:0] CFG_OPACITY_MAX = 3'd2;
	localparam logic [2:0] CFG_LIFE_MIN    = 3'd3;
	localparam logic [2:0] CFG_LIFE_MAX    = 3'd4;
	localparam logic [2:0] CFG_SPEED_MIN   = 3'd5;
	localparam logic [2:0] CFG_SPEED_MAX   = 3'd6;
	localparam logic [2:0] CFG_TILE_COUNT  = 3'd7;

	// Register reset values
	localparam logic [10:0] RST_MAX_COUNT   = 11'd512;
	localparam logic [16:0] RST_OPACITY_MIN = 17'd32768;
	localparam logic [16:0] RST_OPACITY_MAX = 17'd65536;
	localparam logic [23:0] RST_LIFE_MIN    = 24'd327680;
	localparam logic [23:0] RST_LIFE_MAX    = 24'd917504;
	localparam logic [23:0] RST_SPEED_MIN   = 24'd19661;
	localparam logic [23:0] RST_SPEED_MAX   = 24'd65536;
	localparam logic [4:0]  RST_TILE_COUNT  = 5'd9;

	// Fixed-point limits
	localparam logic [23:0] MAX24    = 24'hFFFFFF;
	localparam logic [23:0] OPA_TOP  = 24'd65536;
	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [4:0]  TILE_MAX = 5'd16;

	// One pool entry as stored in memory
	typedef struct packed {
		logic [23:0] x;
		logic [23:0] y;
		logic [23:0] z;
		logic [16:0] opa;
		logic [23:0] spd;
		logic [23:0] life;
		logic [23:0] age;
		logic [3:0]  tile;
	} entry_t;

endpackage
`default_nettype wire

[design/ppm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ppm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                     clk,
	input  wire                                     we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                        wdata,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[design/particle_pool_manager_unit.sv]
// Top level of the particle pool manager: control sequencer around the entry memory.
//
// Particle pool with CAPACITY slots kept dense by swap-with-last removal. A command is
// taken when start is high and busy is low; its single result appears for exactly one
// cycle with done high and cannot be stalled, so the receiver must take it then. Busy
// drops in the same cycle that done rises, so the next command may follow at once.
// All entries live in one memory with one write and one registered read port, and that
// port sets the timing. Clear, and an add while adds are disabled, finish straight from
// idle; a read passes through a read state and an output state; an add runs the three
// bound pairs through the shared multiplier, and may wait on the tile round robin when
// the tile count was lowered below the current tile, as it needs one subtract per cycle
// to wrap. A tick first ages every live entry, then checks each for expiry, moving the
// last entry into the slot of an expired one. The memory is not cleared; only slots
// below the live count reach the results.
`timescale 1ns / 1ps
`default_nettype none
module particle_pool_manager_unit #(
	parameter int CAPACITY = 1024
) (
	input  wire                clk,
	input  wire                arst_n,
	// command side
	input  wire                start,
	output logic               busy,
	input  wire  [1:0]         op,
	input  wire  signed [23:0] start_x,
	input  wire  signed [23:0] start_y,
	input  wire  signed [23:0] start_z,
	input  wire  [16:0]        fraction,
	input  wire  [23:0]        delta_time,
	input  wire  [9:0]         entry_index,
	// result side
	output logic               done,
	output logic signed [23:0] out_x,
	output logic signed [23:0] out_y,
	output logic signed [23:0] out_z,
	output logic [16:0]        opacity,
	output logic [23:0]        speed,
	output logic [23:0]        lifetime,
	output logic [23:0]        age,
	output logic [3:0]         tile,
	output logic [10:0]        live_count,
	output logic [9:0]         slot,
	output logic [10:0]        dropped,
	// configuration write channel
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [2:0]         cfg_index,
	input  wire  [23:0]        cfg_data
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = $bits(ppm_pkg::entry_t);

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_ADD     = 9'b000000010,
		ST_AGE     = 9'b000000100,
		ST_CHK_RD  = 9'b000001000,
		ST_CHK_EV  = 9'b000010000,
		ST_MOVE    = 9'b000100000,
		ST_CHK_CUR = 9'b001000000,
		ST_READ    = 9'b010000000,
		ST_RD_OUT  = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [10:0] max_count_q;
	logic [16:0] opa_min_q, opa_max_q;
	logic [23:0] life_min_q, life_max_q, spd_min_q, spd_max_q;
	logic [4:0]  tile_count_q;

	// pool state
	logic [CW-1:0] count_q;
	logic [3:0]    next_tile_q;

	// command registers
	logic [23:0]   x_q, y_q, z_q;
	logic [16:0]   f_q;
	logic [23:0]   dt_q;
	logic [9:0]    idx_q;
	logic [AW-1:0] slot_q;
	logic [CW-1:0] new_count_q;
	logic [10:0]   drop_q;
	logic [2:0]    k_q;
	logic [4:0]    t_q;
	logic [16:0]   opa_q;
	logic [23:0]   spd_q, life_q;
	logic [CW-1:0] ptr_q;
	logic [10:0]   removed_q;
	ppm_pkg::entry_t cur_q;

	// pipeline registers
	logic signed [42:0] prod_s1;
	logic [1:0]         k_s1;
	logic               pv_s1;
	logic               age_v_s1;
	logic [AW-1:0]      addr_s1;

	// memory ports
	logic            ram_we;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	ppm_pkg::entry_t ram_wdata, ram_rdata;
	logic [EW-1:0]   ram_rdata_raw;

	ppm_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);
	assign ram_rdata = ppm_pkg::entry_t'(ram_rdata_raw);

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	wire accept = start && !busy;

	// effective limits
	logic [12:0]   lim13;
	logic [CW-1:0] limit;
	logic [4:0]    tc;
	always_comb begin
		lim13 = ({2'b0, max_count_q} > 13'(CAPACITY)) ? 13'(CAPACITY) : {2'b0, max_count_q};
		limit = CW'(lim13);
		if (tile_count_q == 5'd0) begin
			tc = 5'd1;
		end else if (tile_count_q > ppm_pkg::TILE_MAX) begin
			tc = ppm_pkg::TILE_MAX;
		end else begin
			tc = tile_count_q;
		end
	end

	// interpolation operands for the issuing and finishing steps
	logic [23:0]        lo_k, hi_k, lo_s, top_s;
	logic signed [24:0] diff;
	logic signed [17:0] f_sg;
	logic signed [42:0] mul_p, acc;
	logic [26:0]        v_raw;
	logic [23:0]        v_sat;
	always_comb begin
		case (k_q[1:0])
			2'd0: begin
				lo_k = {7'b0, opa_min_q};
				hi_k = {7'b0, opa_max_q};
			end
			2'd1: begin
				lo_k = spd_min_q;
				hi_k = spd_max_q;
			end
			default: begin
				lo_k = life_min_q;
				hi_k = life_max_q;
			end
		endcase
		case (k_s1)
			2'd0: begin
				lo_s  = {7'b0, opa_min_q};
				top_s = ppm_pkg::OPA_TOP;
			end
			2'd1: begin
				lo_s  = spd_min_q;
				top_s = ppm_pkg::MAX24;
			end
			default: begin
				lo_s  = life_min_q;
				top_s = ppm_pkg::MAX24;
			end
		endcase
		diff  = $signed({1'b0, hi_k}) - $signed({1'b0, lo_k});
		f_sg  = $signed({1'b0, f_q});
		mul_p = diff * f_sg;
		// lo * 65536 + (hi - lo) * f + half, then drop the fraction
		acc   = $signed({3'b0, lo_s, 16'b0}) + prod_s1 + 43'sd32768;
		v_raw = acc[42:16];
		v_sat = (v_raw > {3'b0, top_s}) ? top_s : v_raw[23:0];
	end

	// aging of the entry just read
	logic [24:0] age_sum;
	logic [23:0] age_new;
	assign age_sum = {1'b0, ram_rdata.age} + {1'b0, dt_q};
	assign age_new = age_sum[24] ? ppm_pkg::MAX24 : age_sum[23:0];

	// expiry check on a fresh read or on the entry just moved in
	ppm_pkg::entry_t ev;
	logic            expired;
	assign ev      = (state_q == ST_CHK_EV) ? ram_rdata : cur_q;
	assign expired = ev.age > ev.life;

	logic ptr_live;
	logic add_go;
	assign ptr_live = ptr_q < count_q;
	assign add_go   = (k_q == 3'd4) && (t_q < tc);

	// memory access control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = ram_rdata;
		ram_raddr = ptr_q[AW-1:0];
		unique case (state_q)
			ST_ADD: begin
				ram_we         = add_go;
				ram_wdata.x    = x_q;
				ram_wdata.y    = y_q;
				ram_wdata.z    = z_q;
				ram_wdata.opa  = opa_q;
				ram_wdata.spd  = spd_q;
				ram_wdata.life = life_q;
				ram_wdata.age  = 24'd0;
				ram_wdata.tile = next_tile_q;
			end
			ST_AGE: begin
				ram_we        = age_v_s1;
				ram_waddr     = addr_s1;
				ram_wdata.age = age_new;
			end
			ST_CHK_EV, ST_CHK_CUR: begin
				ram_raddr = AW'(count_q - CW'(1));
			end
			ST_MOVE: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q[AW-1:0];
			end
			ST_READ: begin
				ram_raddr = AW'(idx_q);
			end
			default: begin
			end
		endcase
	end

	// result formation
	logic            fin;
	ppm_pkg::entry_t r_ent;
	logic [10:0]     r_live, r_drop;
	logic [9:0]      r_slot;
	logic [CW-1:0]   drop_n;
	always_comb begin
		fin    = 1'b0;
		r_ent  = '0;
		r_live = 11'(count_q);
		r_drop = 11'd0;
		r_slot = 10'd0;
		drop_n = count_q - limit + CW'(1);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (op == ppm_pkg::OP_CLEAR)) begin
					fin    = 1'b1;
					r_live = 11'd0;
				end else if (accept && (op == ppm_pkg::OP_ADD) && (limit == '0)) begin
					fin = 1'b1;
				end
			end
			ST_ADD: begin
				if (add_go) begin
					fin        = 1'b1;
					r_ent.tile = next_tile_q;
					r_slot     = 10'(slot_q);
					r_drop     = drop_q;
					r_live     = 11'(new_count_q);
				end
			end
			ST_CHK_RD: begin
				if (!ptr_live) begin
					fin    = 1'b1;
					r_drop = removed_q;
				end
			end
			ST_RD_OUT: begin
				fin    = 1'b1;
				r_slot = idx_q;
				if ({3'b0, idx_q} < 13'(count_q)) begin
					r_ent = ram_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q  <= ppm_pkg::RST_MAX_COUNT;
			opa_min_q    <= ppm_pkg::RST_OPACITY_MIN;
			opa_max_q    <= ppm_pkg::RST_OPACITY_MAX;
			life_min_q   <= ppm_pkg::RST_LIFE_MIN;
			life_max_q   <= ppm_pkg::RST_LIFE_MAX;
			spd_min_q    <= ppm_pkg::RST_SPEED_MIN;
			spd_max_q    <= ppm_pkg::RST_SPEED_MAX;
			tile_count_q <= ppm_pkg::RST_TILE_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ppm_pkg::CFG_MAX_COUNT:   max_count_q  <= cfg_data[10:0];
				ppm_pkg::CFG_OPACITY_MIN: opa_min_q    <= cfg_data[16:0];
				ppm_pkg::CFG_OPACITY_MAX: opa_max_q    <= cfg_data[16:0];
				ppm_pkg::CFG_LIFE_MIN:    life_min_q   <= cfg_data;
				ppm_pkg::CFG_LIFE_MAX:    life_max_q   <= cfg_data;
				ppm_pkg::CFG_SPEED_MIN:   spd_min_q    <= cfg_data;
				ppm_pkg::CFG_SPEED_MAX:   spd_max_q    <= cfg_data;
				ppm_pkg::CFG_TILE_COUNT:  tile_count_q <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_x      <= r_ent.x;
			out_y      <= r_ent.y;
			out_z      <= r_ent.z;
			opacity    <= r_ent.opa;
			speed      <= r_ent.spd;
			lifetime   <= r_ent.life;
			age        <= r_ent.age;
			tile       <= r_ent.tile;
			live_count <= r_live;
			slot       <= r_slot;
			dropped    <= r_drop;
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			next_tile_q <= 4'd0;
			k_q         <= 3'd0;
			pv_s1       <= 1'b0;
			age_v_s1    <= 1'b0;
			ptr_q       <= '0;
			removed_q   <= 11'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							ppm_pkg::OP_ADD: begin
								if (limit != '0) begin
									if (count_q >= limit) begin
										drop_q      <= 11'(drop_n);
										slot_q      <= AW'(limit - CW'(1));
										new_count_q <= limit;
									end else begin
										drop_q      <= 11'd0;
										slot_q      <= AW'(count_q);
										new_count_q <= count_q + CW'(1);
									end
									x_q     <= start_x;
									y_q     <= start_y;
									z_q     <= start_z;
									f_q     <= (fraction > ppm_pkg::ONE_Q16) ?
										ppm_pkg::ONE_Q16 : fraction;
									k_q     <= 3'd0;
									pv_s1   <= 1'b0;
									t_q     <= {1'b0, next_tile_q} + 5'd1;
									state_q <= ST_ADD;
								end
							end
							ppm_pkg::OP_TICK: begin
								dt_q      <= delta_time;
								ptr_q     <= '0;
								age_v_s1  <= 1'b0;
								removed_q <= 11'd0;
								state_q   <= ST_AGE;
							end
							ppm_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							default: begin
								idx_q   <= entry_index;
								state_q <= ST_READ;
							end
						endcase
					end
				end
				ST_ADD: begin
					// shared multiplier, one bound pair per cycle
					if (k_q < 3'd3) begin
						prod_s1 <= mul_p;
						k_s1    <= k_q[1:0];
						pv_s1   <= 1'b1;
					end else begin
						pv_s1 <= 1'b0;
					end
					if (k_q < 3'd4) begin
						k_q <= k_q + 3'd1;
					end
					if (pv_s1) begin
						case (k_s1)
							2'd0:    opa_q  <= v_sat[16:0];
							2'd1:    spd_q  <= v_sat;
							default: life_q <= v_sat;
						endcase
					end
					// tile round robin reduced one subtract per cycle
					if (t_q >= tc) begin
						t_q <= t_q - tc;
					end
					if (add_go) begin
						count_q     <= new_count_q;
						next_tile_q <= t_q[3:0];
						state_q     <= ST_IDLE;
					end
				end
				ST_AGE: begin
					// read one entry per cycle, write it back aged in the next cycle
					if (ptr_live) begin
						ptr_q    <= ptr_q + CW'(1);
						addr_s1  <= ptr_q[AW-1:0];
						age_v_s1 <= 1'b1;
					end else begin
						age_v_s1 <= 1'b0;
						if (!age_v_s1) begin
							ptr_q   <= '0;
							state_q <= ST_CHK_RD;
						end
					end
				end
				ST_CHK_RD: begin
					state_q <= ptr_live ? ST_CHK_EV : ST_IDLE;
				end
				ST_CHK_EV, ST_CHK_CUR: begin
					if (!expired) begin
						ptr_q   <= ptr_q + CW'(1);
						state_q <= ST_CHK_RD;
					end else begin
						removed_q <= removed_q + 11'd1;
						if (ptr_q == count_q - CW'(1)) begin
							count_q <= count_q - CW'(1);
							state_q <= ST_CHK_RD;
						end else begin
							state_q <= ST_MOVE;
						end
					end
				end
				ST_MOVE: begin
					// last entry lands in the freed slot and is checked again
					cur_q   <= ram_rdata;
					count_q <= count_q - CW'(1);
					state_q <= ST_CHK_CUR;
				end
				ST_READ: begin
					state_q <= ST_RD_OUT;
				end
				ST_RD_OUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
